// ===== rtl/core/rswg_pkg.sv =====
// ----------------------------------------------------------------------------
// rswg_pkg
// shared widths, register indexes, reset values and led codes of the rssi
// window signal grader
// ----------------------------------------------------------------------------
`default_nettype none

package rswg_pkg;

  localparam int WINDOW    = 10;
  localparam int RSSI_W    = 8;
  localparam int MARGIN_W  = 5;
  localparam int LED_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = RSSI_W + CNT_W;
  localparam int SQ_W   = 2 * RSSI_W - 2 + CNT_W;
  localparam int TGT_W  = RSSI_W + 1;
  localparam int NT_W   = CNT_W + 1 + TGT_W;
  localparam int D_W    = CNT_W + 1 + RSSI_W;
  localparam int MA_W   = D_W;
  localparam int MB_W   = SQ_W + 1;
  localparam int PROD_W = MA_W + MB_W;

  localparam logic [CFG_IDX_W-1:0] REG_STRONG_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_MARGIN = 2'd2;

  localparam logic [RSSI_W-1:0]   STRONG_LEVEL_RST  = 8'hC4;
  localparam logic [RSSI_W-1:0]   FLOOR_LEVEL_RST   = 8'hB0;
  localparam logic [MARGIN_W-1:0] STRONG_MARGIN_RST = 5'd5;

  localparam logic [LED_W-1:0] LED_KEEP   = 2'd0;
  localparam logic [LED_W-1:0] LED_NORMAL = 2'd1;
  localparam logic [LED_W-1:0] LED_STRONG = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

`default_nettype wire

// ===== rtl/core/rswg_ram.sv =====
// ----------------------------------------------------------------------------
// rswg_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rswg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rssi_window_signal_grader_top.sv =====
// ----------------------------------------------------------------------------
// rssi_window_signal_grader_top
// grades polled rssi samples for a signal led: a first compare after link up,
// then mean and deviation tests over a ring of recent samples
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       input      in_valid/in_ready  wireless_enabled, link_up, rssi
//  out      output     out_valid/out_ready led_command, slow_poll
//  cfg      input      cfg_we             cfg_index, cfg_wdata
//
//  disabled, link down and first stage items go from accept straight to the
//  output step; second stage items read the ring on accept, then update, make
//  three passes through the shared multiplier and take a decision step
//  one item is in work at a time; in_ready is high while the sequencer idles
//  a waiting result sits in the output register and holds only the last step
//  synchronous active low reset; the sample ring needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_window_signal_grader_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_wireless_enabled,
  input  wire logic                                in_link_up,
  input  wire logic signed [rswg_pkg::RSSI_W-1:0]  in_rssi,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [rswg_pkg::LED_W-1:0]   out_led_command,
  output logic                                     out_slow_poll,
  input  wire logic                                cfg_we,
  input  wire logic        [rswg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [rswg_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_M1   = 3'd2;
  localparam logic [2:0] ST_M2   = 3'd3;
  localparam logic [2:0] ST_M3   = 3'd4;
  localparam logic [2:0] ST_DEC  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  // configuration
  logic signed [rswg_pkg::RSSI_W-1:0]   strong_r;
  logic signed [rswg_pkg::RSSI_W-1:0]   floor_r;
  logic        [rswg_pkg::MARGIN_W-1:0] margin_r;

  // control and window state
  logic [2:0]          state_r, state_nxt;
  logic                stage_r, stage_nxt;
  rswg_pkg::slot_t     slot_r, slot_nxt;
  rswg_pkg::cnt_t      fill_r, fill_nxt;
  logic signed [rswg_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic        [rswg_pkg::SQ_W-1:0]  sq_r, sq_nxt;
  logic                out_valid_r, out_valid_nxt;

  // datapath
  logic signed [rswg_pkg::RSSI_W-1:0]  rssi_r, rssi_nxt;
  logic [rswg_pkg::LED_W-1:0]          res_led_r, res_led_nxt;
  logic                                res_slow_r, res_slow_nxt;
  logic [rswg_pkg::LED_W-1:0]          out_led_r, out_led_nxt;
  logic                                out_slow_r, out_slow_nxt;
  logic                                ge_r, ge_nxt;
  logic signed [rswg_pkg::D_W-1:0]     d_r, d_nxt;
  logic signed [rswg_pkg::PROD_W-1:0]  p_r;
  logic signed [rswg_pkg::PROD_W-1:0]  acc_r, acc_nxt;

  logic                                accept;
  logic                                full;
  logic                                out_free;
  logic                                ram_re;
  logic                                ram_we;
  logic [rswg_pkg::RSSI_W-1:0]         ram_rdata;
  logic signed [rswg_pkg::RSSI_W-1:0]  old;
  logic signed [2*rswg_pkg::RSSI_W-1:0] old_sq;
  logic signed [2*rswg_pkg::RSSI_W-1:0] new_sq;
  logic signed [rswg_pkg::TGT_W-1:0]   tgt;
  logic signed [rswg_pkg::NT_W-1:0]    n_tgt;
  logic signed [rswg_pkg::NT_W-1:0]    sum_wide;
  logic signed [rswg_pkg::D_W-1:0]     n_floor;
  logic signed [rswg_pkg::CNT_W:0]     n_s;
  logic signed [rswg_pkg::MA_W-1:0]    mul_a;
  logic signed [rswg_pkg::MB_W-1:0]    mul_b;
  logic signed [rswg_pkg::PROD_W-1:0]  prod;

  rswg_ram #(
    .WIDTH (rswg_pkg::RSSI_W),
    .DEPTH (rswg_pkg::WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (rssi_r),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign accept          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_led_command = out_led_r;
  assign out_slow_poll   = out_slow_r;

  assign full     = (fill_r == rswg_pkg::CNT_W'(rswg_pkg::WINDOW));
  assign out_free = !out_valid_r || out_ready;
  assign ram_re   = accept && in_wireless_enabled && in_link_up && stage_r;
  assign ram_we   = (state_r == ST_UPD);

  // window arithmetic
  assign old      = full ? $signed(ram_rdata) : '0;
  assign old_sq   = old * old;
  assign new_sq   = rssi_r * rssi_r;
  assign n_s      = $signed({1'b0, fill_r});
  assign tgt      = rswg_pkg::TGT_W'(strong_r) + rswg_pkg::TGT_W'($signed({1'b0, margin_r}));
  assign n_tgt    = n_s * tgt;
  assign n_floor  = n_s * floor_r;
  assign sum_wide = rswg_pkg::NT_W'(sum_r);

  // shared multiplier
  always_comb begin
    case (state_r)
      ST_M1: begin
        mul_a = rswg_pkg::MA_W'(n_s);
        mul_b = $signed({1'b0, sq_r});
      end
      ST_M2: begin
        mul_a = rswg_pkg::MA_W'(sum_r);
        mul_b = rswg_pkg::MB_W'(sum_r);
      end
      ST_M3: begin
        mul_a = d_r;
        mul_b = rswg_pkg::MB_W'(d_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    rssi_nxt      = rssi_r;
    res_led_nxt   = res_led_r;
    res_slow_nxt  = res_slow_r;
    ge_nxt        = ge_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_led_nxt   = out_led_r;
    out_slow_nxt  = out_slow_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rssi_nxt = in_rssi;
          if (!in_wireless_enabled) begin
            res_led_nxt  = rswg_pkg::LED_KEEP;
            res_slow_nxt = stage_r;
            state_nxt    = ST_OUT;
          end else if (!in_link_up) begin
            stage_nxt    = 1'b0;
            res_led_nxt  = rswg_pkg::LED_KEEP;
            res_slow_nxt = 1'b0;
            state_nxt    = ST_OUT;
          end else if (!stage_r) begin
            res_led_nxt  = (in_rssi >= strong_r) ? rswg_pkg::LED_STRONG
                                                 : rswg_pkg::LED_NORMAL;
            res_slow_nxt = 1'b1;
            stage_nxt    = 1'b1;
            slot_nxt     = '0;
            fill_nxt     = '0;
            sum_nxt      = '0;
            sq_nxt       = '0;
            state_nxt    = ST_OUT;
          end else begin
            res_slow_nxt = 1'b1;
            state_nxt    = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        sum_nxt  = sum_r - rswg_pkg::SUM_W'(old) + rswg_pkg::SUM_W'(rssi_r);
        sq_nxt   = sq_r - rswg_pkg::SQ_W'($unsigned(old_sq))
                        + rswg_pkg::SQ_W'($unsigned(new_sq));
        fill_nxt = full ? fill_r : fill_r + 1'b1;
        slot_nxt = (slot_r == rswg_pkg::SLOT_W'(rswg_pkg::WINDOW - 1)) ? '0
                                                                      : slot_r + 1'b1;
        state_nxt = ST_M1;
      end
      ST_M1: begin
        ge_nxt    = (sum_wide >= n_tgt);
        d_nxt     = rswg_pkg::D_W'(sum_r) - n_floor;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        acc_nxt   = p_r;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        acc_nxt   = acc_r - p_r;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        res_led_nxt = (ge_r && !d_r[rswg_pkg::D_W-1] && (p_r >= acc_r))
                      ? rswg_pkg::LED_STRONG : rswg_pkg::LED_NORMAL;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_led_nxt   = res_led_r;
          out_slow_nxt  = res_slow_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= 1'b0;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
      strong_r    <= rswg_pkg::STRONG_LEVEL_RST;
      floor_r     <= rswg_pkg::FLOOR_LEVEL_RST;
      margin_r    <= rswg_pkg::STRONG_MARGIN_RST;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rswg_pkg::REG_STRONG_LEVEL:  strong_r <= $signed(cfg_wdata);
          rswg_pkg::REG_FLOOR_LEVEL:   floor_r  <= $signed(cfg_wdata);
          rswg_pkg::REG_STRONG_MARGIN: margin_r <= cfg_wdata[rswg_pkg::MARGIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rssi_r     <= rssi_nxt;
    res_led_r  <= res_led_nxt;
    res_slow_r <= res_slow_nxt;
    out_led_r  <= out_led_nxt;
    out_slow_r <= out_slow_nxt;
    ge_r       <= ge_nxt;
    d_r        <= d_nxt;
    acc_r      <= acc_nxt;
    p_r        <= prod;
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= rswg_pkg::CNT_W'(rswg_pkg::WINDOW))
    else $error("fill count beyond window");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (rswg_pkg::CNT_W'(slot_r) == fill_r))
    else $error("write slot out of step with fill count");

  a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (sum_r == '0 && sq_r == '0))
    else $error("empty window with nonzero sums");

  a_var_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) |-> !acc_r[rswg_pkg::PROD_W-1])
    else $error("negative scaled variance");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into output register");
`endif

endmodule

`default_nettype wire
